>>> hw/rtl/two_d_parity_error_correct_unit_defines.svh
// ---------------------------------------------------------------------------
// Two-dimensional parity unit assertion macros
// Shared assertion shorthands for the parity correction unit's checker.
// ---------------------------------------------------------------------------
`ifndef TWO_D_PARITY_ERROR_CORRECT_UNIT_DEFINES_SVH
`define TWO_D_PARITY_ERROR_CORRECT_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TDPEC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TDPEC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/tdpec_pkg.sv
// ---------------------------------------------------------------------------
// Two-dimensional parity unit package
// Sizes, codes and helper functions shared by the controller and datapath.
// ---------------------------------------------------------------------------
package tdpec_pkg;

  localparam int MAX_N       = 32;
  localparam int SIZE_CAP    = (MAX_N < 32) ? MAX_N : 32;
  localparam int STORE_DEPTH = SIZE_CAP;
  localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int ROW_W       = 32;
  localparam int CFG_W       = 6;
  localparam int POS_W       = 5;
  localparam int OUT_W       = ROW_W + POS_W + 1 + POS_W + POS_W + 1 + 1 - 2;

  typedef enum logic [1:0] {
    KIND_ROW   = 2'd0,
    KIND_RXROW = 2'd1,
    KIND_CHECK = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOCATE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic absorb;   // store a data row and fold it into the parities
    logic take_rx;  // latch the received row-parity vector
    logic capture;  // latch both mismatch vectors
    logic locate;   // encode the error position and rewind the read pointer
    logic emit;     // stream rows out of the store
    logic clear;    // return the accumulators to zero
  } cmd_t;

  typedef struct packed {
    logic last_sent;
  } sts_t;

  // Effective matrix size: zero acts as one, large values saturate.
  function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] cfg);
    logic [CFG_W-1:0] n;
    n = cfg;
    if (cfg == '0) begin
      n = CFG_W'(1);
    end else if (cfg > CFG_W'(SIZE_CAP)) begin
      n = CFG_W'(SIZE_CAP);
    end
    return n;
  endfunction

  function automatic logic [ROW_W-1:0] size_mask(input logic [CFG_W-1:0] n);
    logic [ROW_W-1:0] m;
    for (int j = 0; j < ROW_W; j++) begin
      m[j] = (CFG_W'(j) < n);
    end
    return m;
  endfunction

  // Index of the lowest set bit, zero when none is set.
  function automatic logic [POS_W-1:0] lowest_set(input logic [ROW_W-1:0] v);
    logic [POS_W-1:0] pos;
    pos = '0;
    for (int j = ROW_W - 1; j >= 0; j--) begin
      if (v[j]) begin
        pos = POS_W'(j);
      end
    end
    return pos;
  endfunction

endpackage

>>> hw/rtl/tdpec_ctrl.sv
// ---------------------------------------------------------------------------
// Two-dimensional parity unit controller
// Sequences row loading, the parity check and the streaming of rows.
// ---------------------------------------------------------------------------
module tdpec_ctrl import tdpec_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_kind_i,
  output logic       in_ready_o,
  output cmd_t       cmd_o,
  input  sts_t       sts_i
);

  state_e state_q, state_d;
  kind_e  kind;

  assign kind = kind_e'(in_kind_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (kind)
            KIND_ROW:   cmd_o.absorb  = 1'b1;
            KIND_RXROW: cmd_o.take_rx = 1'b1;
            KIND_CHECK: begin
              cmd_o.capture = 1'b1;
              state_d       = ST_LOCATE;
            end
            default: ;
          endcase
        end
      end
      ST_LOCATE: begin
        cmd_o.locate = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (sts_i.last_sent) begin
          cmd_o.clear = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/tdpec_dpath.sv
// ---------------------------------------------------------------------------
// Two-dimensional parity unit datapath
// Row store, parity accumulators, error locator and the output pipeline.
// ---------------------------------------------------------------------------
module tdpec_dpath import tdpec_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic [ROW_W-1:0] in_word_i,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [OUT_W-1:0] out_data_o,
  output logic             out_last_o
);

  logic [ROW_W-1:0] mem [STORE_DEPTH];

  logic [CFG_W-1:0] size_q;
  logic [CNT_W-1:0] rows_loaded_q;
  logic [ROW_W-1:0] row_par_q, col_par_q, rx_row_par_q;
  logic [ROW_W-1:0] rdiff_q, cdiff_q;
  logic             found_q;
  logic [POS_W-1:0] erow_q, ecol_q;
  logic [CNT_W-1:0] issue_idx_q;
  logic             rd_valid_q, rd_last_q, rd_zero_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic [ROW_W-1:0] rd_data_q;
  logic             out_valid_q, out_last_q;
  logic [OUT_W-1:0] out_data_q;

  logic [CFG_W-1:0] n;
  logic [ROW_W-1:0] m, row_in, row_out;
  logic             room, rd_en, ld_out;

  assign n      = eff_size(size_q);
  assign m      = size_mask(n);
  assign row_in = in_word_i & m;
  assign room   = CFG_W'(rows_loaded_q) < n;

  // The read stage advances when it is empty or hands its row to the output.
  assign ld_out = rd_valid_q && (!out_valid_q || out_ready_i);
  assign rd_en  = cmd_i.emit && (CFG_W'(issue_idx_q) < n) && (!rd_valid_q || ld_out);

  always_comb begin
    row_out = rd_zero_q ? '0 : rd_data_q;
    if (found_q && (POS_W'(rd_idx_q) == erow_q)) begin
      row_out = row_out ^ (ROW_W'(1) << ecol_q);
    end
    row_out = row_out & m;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.absorb && room) begin
      mem[rows_loaded_q[IDX_W-1:0]] <= row_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[issue_idx_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q        <= CFG_W'(32);
      rows_loaded_q <= '0;
      row_par_q     <= '0;
      col_par_q     <= '0;
      rx_row_par_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_data_i;
      end
      if (cmd_i.clear) begin
        rows_loaded_q <= '0;
        row_par_q     <= '0;
        col_par_q     <= '0;
        rx_row_par_q  <= '0;
      end else begin
        if (cmd_i.absorb && room) begin
          rows_loaded_q                      <= rows_loaded_q + 1'b1;
          row_par_q[rows_loaded_q[IDX_W-1:0]] <= ^row_in;
          col_par_q                          <= col_par_q ^ row_in;
        end
        if (cmd_i.take_rx) begin
          rx_row_par_q <= in_word_i;
        end
      end
    end
  end

  // Locator and read pointer; only meaningful once a check has started.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rdiff_q <= (row_par_q ^ rx_row_par_q) & m;
      cdiff_q <= (col_par_q ^ in_word_i) & m;
    end
    if (cmd_i.locate) begin
      found_q <= (|rdiff_q) && (|cdiff_q);
      erow_q  <= lowest_set(rdiff_q);
      ecol_q  <= lowest_set(cdiff_q);
    end
    if (rd_en) begin
      rd_idx_q  <= issue_idx_q[IDX_W-1:0];
      rd_last_q <= (CFG_W'(issue_idx_q) + 1'b1) == n;
      rd_zero_q <= issue_idx_q >= rows_loaded_q;
    end
    if (ld_out) begin
      out_data_q <= {ecol_q, erow_q, found_q, POS_W'(rd_idx_q), row_out};
      out_last_q <= rd_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_idx_q <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.locate) begin
        issue_idx_q <= '0;
      end else if (rd_en) begin
        issue_idx_q <= issue_idx_q + 1'b1;
      end
      if (rd_en) begin
        rd_valid_q <= 1'b1;
      end else if (ld_out) begin
        rd_valid_q <= 1'b0;
      end
      if (ld_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.last_sent = out_valid_q && out_ready_i && out_last_q;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;
  assign out_last_o      = out_last_q;

endmodule

>>> hw/rtl/two_d_parity_error_correct_unit.sv
// ---------------------------------------------------------------------------
// Two-dimensional parity error correction unit
// Stores a square bit matrix, checks it against received row and column
// parity vectors, corrects a single bit error and streams the rows out.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Signals                      Word contents
//  s_axis    in         tvalid/tready/tdata/tuser    tdata: word, tuser: kind
//  m_axis    out        tvalid/tready/tdata/tlast    corrected row and error info
//  cfg       in         valid/ready/data             matrix size (6 bits)
//
// A data row or a row-parity word is taken whenever the unit is idle, and such
// words may follow one another in every cycle. A column-parity word starts the
// check: the mismatch vectors are captured as it is taken, the error is then
// located, and the rows leave at one per cycle while m_axis is ready, limited
// by the single read port of the row store, via the read and output stages.
// No input word is taken until the last row has been delivered.
// Back-pressure on m_axis holds the read and output stages in place.
// Reset clears the parity accumulators and the row count; the row store needs
// no clearing, as rows that were never loaded are emitted as zero.
// ---------------------------------------------------------------------------
module two_d_parity_error_correct_unit import tdpec_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Input words.
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [31:0]      s_axis_tdata_i,   // [31:0] word
  input  logic [1:0]       s_axis_tuser_i,   // [1:0] kind
  // Corrected rows.
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [OUT_W-1:0] m_axis_tdata_o,   // [31:0] row_bits, [36:32] row_index,
                                             // [37] error_found, [42:38] error_row,
                                             // [47:43] error_col
  output logic             m_axis_tlast_o,   // last
  // Matrix size register.
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // The size register may be written at any time; the writer keeps to idle
  // periods, so no flow control is needed on this channel.
  assign cfg_ready_o = 1'b1;

  // The controller decides what each accepted word does and when rows stream.
  tdpec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_kind_i  (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // The datapath holds the matrix, the parities and the output register.
  tdpec_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_word_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

>>> hw/rtl/tdpec_checker.sv
// ---------------------------------------------------------------------------
// Two-dimensional parity unit checker
// Port-level properties of the parity correction unit, bound to its top.
// ---------------------------------------------------------------------------
`include "two_d_parity_error_correct_unit_defines.svh"

module tdpec_checker import tdpec_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid_i,
  input logic             s_axis_tready_o,
  input logic [1:0]       s_axis_tuser_i,
  input logic             m_axis_tvalid_o,
  input logic             m_axis_tready_i,
  input logic [OUT_W-1:0] m_axis_tdata_o,
  input logic             m_axis_tlast_o
);

  // A stalled row must stay put.
  `TDPEC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o), "stalled row changed")

  // Input words are refused while rows are being delivered.
  `TDPEC_ASSERT_NOW(a_no_input_in_emit, clk_i, rst_ni, m_axis_tvalid_o, !s_axis_tready_o, "input taken during emission")

  // The final row closes the burst.
  `TDPEC_ASSERT_NEXT(a_last_ends, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o, !m_axis_tvalid_o && s_axis_tready_o, "burst did not end after last row")

  // Only an accepted column-parity word stops the input side.
  `TDPEC_ASSERT_NOW(a_busy_cause, clk_i, rst_ni, $fell(s_axis_tready_o), $past(s_axis_tvalid_i) && ($past(s_axis_tuser_i) == KIND_CHECK), "input side stalled without a check word")

endmodule

bind two_d_parity_error_correct_unit tdpec_checker u_checker (.*);

>>> tb/tb_two_d_parity_error_correct_unit.sv
// ---------------------------------------------------------------------------
// Two-dimensional parity correction unit testbench
// Drives row, row-parity and column-parity words into the unit and compares
// every corrected row that leaves it with a cycle-free model of the check.
// A scripted opening covers the corner cases, and random matrices follow
// under changing matrix sizes and changing idle patterns on both streams.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_two_d_parity_error_correct_unit;
  import tdpec_pkg::*;

  localparam int          RANDOM_ITEMS  = 370;
  localparam int          STALL_LIMIT   = 2000;  // cycles with no word moving anywhere
  localparam int          HOLD_CYCLES   = 400;   // long output stall for back-pressure
  localparam int          SETTLE_CYCLES = 6;
  localparam logic [1:0]  KIND_IGNORED  = 2'd3;  // not a defined kind, dropped by the unit

  // One corrected row as it leaves the unit.
  typedef struct packed {
    logic [31:0] bits;
    logic [4:0]  index;
    logic        found;
    logic [4:0]  erow;
    logic [4:0]  ecol;
    logic        last;
  } out_row_t;

  typedef enum logic {DO_WORD, DO_SIZE} step_op_e;

  // A scripted step: either a word for the input stream or a size write.
  // Where typed is set the rows are given here instead of by the model:
  // row 0 carries bits0, every later row is zero.
  typedef struct packed {
    step_op_e    op;
    logic [1:0]  kind;
    logic [31:0] word;
    logic        typed;
    logic [31:0] bits0;
    logic        found;
    logic [4:0]  erow;
    logic [4:0]  ecol;
  } script_step_t;

  localparam int SCRIPT_LEN = 28;
  localparam script_step_t SCRIPT [SCRIPT_LEN] = '{
    // Straight after reset: 32 rows, none loaded, all come out zero.
    '{DO_WORD, KIND_CHECK,   32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0, 5'd0, 5'd0},
    '{DO_WORD, KIND_IGNORED, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, 5'd0, 5'd0},
    // A full row of ones with matching parities: no correction.
    '{DO_WORD, KIND_ROW,     32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, 5'd0, 5'd0},
    '{DO_WORD, KIND_RXROW,   32'h0000_0000, 1'b0, 32'h0, 1'b0, 5'd0, 5'd0},
    '{DO_WORD, KIND_CHECK,   32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0, 5'd0, 5'd0},
    // Error in the top column: bit 31 of row 0 is flipped back to zero.
    '{DO_WORD, KIND_ROW,     32'h8000_0000, 1'b0, 32'h0, 1'b0, 5'd0, 5'd0},
    '{DO_WORD, KIND_RXROW,   32'h0000_0000, 1'b0, 32'h0, 1'b0, 5'd0, 5'd0},
    '{DO_WORD, KIND_CHECK,   32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1, 5'd0, 5'd31},
    // Size zero behaves as one; the second row is surplus and the upper
    // bits of every word must be ignored.
    '{DO_SIZE, KIND_ROW,     32'h0000_0000, 1'b0, 32'h0, 1'b0, 5'd0, 5'd0},
    '{DO_WORD, KIND_ROW,     32'h0000_0003, 1'b0, 32'h0, 1'b0, 5'd0, 5'd0},
    '{DO_WORD, KIND_ROW,     32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, 5'd0, 5'd0},
    '{DO_WORD, KIND_RXROW,   32'hFFFF_FFFE, 1'b0, 32'h0, 1'b0, 5'd0, 5'd0},
    '{DO_WORD, KIND_CHECK,   32'hFFFF_FFFE, 1'b1, 32'h0000_0000, 1'b1, 5'd0, 5'd0},
    // An oversized setting saturates at 32: error in the last row and column
    // of an otherwise empty matrix.
    '{DO_SIZE, KIND_ROW,     32'h0000_003F, 1'b0, 32'h0, 1'b0, 5'd0, 5'd0},
    '{DO_WORD, KIND_RXROW,   32'h8000_0000, 1'b0, 32'h0, 1'b0, 5'd0, 5'd0},
    '{DO_WORD, KIND_CHECK,   32'h8000_0000, 1'b0, 32'h0, 1'b0, 5'd0, 5'd0},
    // Row mismatch alone, then column mismatch alone with a missing row.
    '{DO_SIZE, KIND_ROW,     32'h0000_0002, 1'b0, 32'h0, 1'b0, 5'd0, 5'd0},
    '{DO_WORD, KIND_ROW,     32'h0000_0000, 1'b0, 32'h0, 1'b0, 5'd0, 5'd0},
    '{DO_WORD, KIND_ROW,     32'h0000_0001, 1'b0, 32'h0, 1'b0, 5'd0, 5'd0},
    '{DO_WORD, KIND_RXROW,   32'h0000_0000, 1'b0, 32'h0, 1'b0, 5'd0, 5'd0},
    '{DO_WORD, KIND_CHECK,   32'h0000_0001, 1'b0, 32'h0, 1'b0, 5'd0, 5'd0},
    '{DO_WORD, KIND_ROW,     32'h0000_0001, 1'b0, 32'h0, 1'b0, 5'd0, 5'd0},
    '{DO_WORD, KIND_RXROW,   32'h0000_0001, 1'b0, 32'h0, 1'b0, 5'd0, 5'd0},
    '{DO_WORD, KIND_CHECK,   32'h0000_0003, 1'b0, 32'h0, 1'b0, 5'd0, 5'd0},
    // A size change part way through a matrix keeps the rows already held.
    '{DO_WORD, KIND_ROW,     32'h0000_0003, 1'b0, 32'h0, 1'b0, 5'd0, 5'd0},
    '{DO_SIZE, KIND_ROW,     32'h0000_0004, 1'b0, 32'h0, 1'b0, 5'd0, 5'd0},
    '{DO_WORD, KIND_ROW,     32'h0000_0005, 1'b0, 32'h0, 1'b0, 5'd0, 5'd0},
    '{DO_WORD, KIND_CHECK,   32'h0000_0000, 1'b0, 32'h0, 1'b0, 5'd0, 5'd0}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid_i;
  logic             s_axis_tready_o;
  logic [31:0]      s_axis_tdata_i;   // [31:0] word
  logic [1:0]       s_axis_tuser_i;   // [1:0] kind
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i;
  logic [OUT_W-1:0] m_axis_tdata_o;   // [31:0] row bits, [36:32] row index,
                                      // [37] error found, [42:38] error row,
                                      // [47:43] error column
  logic             m_axis_tlast_o;   // last row of the matrix
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i;

  two_d_parity_error_correct_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  // Model state: a copy of everything the unit keeps between words.
  logic [31:0] held_rows [32];
  logic [31:0] row_parity_acc;
  logic [31:0] col_parity_acc;
  logic [31:0] rx_row_parity;
  int          rows_held;
  logic [5:0]  size_reg;

  out_row_t corrected_rows [32];  // rows worked out for the latest check word
  out_row_t rows_due [$];         // rows still to arrive, oldest first

  int mismatches;
  int items_sent;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  bit hold_pending;
  int quiet_cycles;

  // Clock: 10 ns period.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Model of the check
  // ---------------------------------------------------------------------
  function automatic int active_size();
    int n;
    n = size_reg;
    if (n == 0) n = 1;
    if (n > SIZE_CAP) n = SIZE_CAP;
    return n;
  endfunction

  function automatic logic [31:0] width_mask(input int n);
    return (n >= 32) ? 32'hFFFF_FFFF : (32'd1 << n) - 32'd1;
  endfunction

  function automatic logic [4:0] first_one(input logic [31:0] v);
    for (int j = 0; j < 32; j++) begin
      if (v[j]) return 5'(j);
    end
    return 5'd0;
  endfunction

  // Takes one accepted word; for a column-parity word the corrected rows are
  // left in corrected_rows and their number is returned.
  function automatic int parity_step(input logic [1:0] k, input logic [31:0] w);
    int          n;
    logic [31:0] m;
    logic [31:0] r;
    logic [31:0] rdiff;
    logic [31:0] cdiff;
    logic [31:0] bits;
    logic [4:0]  erow;
    logic [4:0]  ecol;
    logic        found;
    n = active_size();
    m = width_mask(n);
    if (k == KIND_ROW) begin
      r = w & m;
      // Rows beyond the matrix size are dropped.
      if (rows_held < n) begin
        held_rows[rows_held]      = r;
        row_parity_acc[rows_held] = ^r;
        col_parity_acc            = col_parity_acc ^ r;
        rows_held++;
      end
      return 0;
    end
    if (k == KIND_RXROW) begin
      rx_row_parity = w;
      return 0;
    end
    if (k != KIND_CHECK) return 0;

    rdiff = (row_parity_acc ^ rx_row_parity) & m;
    cdiff = (col_parity_acc ^ w) & m;
    erow  = first_one(rdiff);
    ecol  = first_one(cdiff);
    found = (rdiff != '0) && (cdiff != '0);
    for (int i = 0; i < n; i++) begin
      // Rows that were never loaded read as zero.
      bits = (i < rows_held) ? held_rows[i] : '0;
      if (found && (i == erow)) bits[ecol] = ~bits[ecol];
      corrected_rows[i].bits  = bits & m;
      corrected_rows[i].index = 5'(i);
      corrected_rows[i].found = found;
      corrected_rows[i].erow  = erow;
      corrected_rows[i].ecol  = ecol;
      corrected_rows[i].last  = (i == n - 1);
    end
    row_parity_acc = '0;
    col_parity_acc = '0;
    rx_row_parity  = '0;
    rows_held      = 0;
    return n;
  endfunction

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------
  // Offers one word, starting at the next falling edge, and returns at the
  // rising edge where it is taken. tvalid stays high until the next call or
  // until the stream is put to rest, so back-to-back words need no gap.
  task automatic put_word(input logic [1:0] k, input logic [31:0] w);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= w;
    s_axis_tuser_i  <= k;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Sends a word and runs the model on it; returns the number of rows due.
  task automatic send_item(input logic [1:0] k, input logic [31:0] w,
                           input bit queue_rows, output int n);
    put_word(k, w);
    n = parity_step(k, w);
    if (queue_rows) begin
      for (int i = 0; i < n; i++) rows_due.push_back(corrected_rows[i]);
    end
    if (k != KIND_IGNORED) items_sent++;
  endtask

  // Drops tvalid, then waits until every expected row has come out and the
  // unit has had time to return to idle. Ends on a falling edge.
  task automatic drain_unit();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (rows_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_size(input logic [5:0] v);
    drain_unit();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    size_reg = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [5:0] random_size();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return 6'($urandom_range(8, 1));
    if (pick < 85) return 6'($urandom_range(31, 9));
    if (pick < 90) return 6'd0;
    if (pick < 95) return 6'd32;
    return 6'($urandom_range(63, 33));
  endfunction

  // One matrix with random contents: mostly a full set of rows, sometimes
  // too few or too many, then the parity vectors with a chosen fault.
  task automatic send_matrix();
    int          n;
    int          cnt;
    int          pick;
    int          dummy;
    int          ri;
    int          ci;
    logic [31:0] w;
    logic [31:0] rx;
    logic [31:0] col;
    logic [31:0] junk_mask;
    n    = active_size();
    pick = $urandom_range(99);
    if (pick < 70)      cnt = n;
    else if (pick < 85) cnt = $urandom_range(n - 1, 0);
    else                cnt = n + $urandom_range(3, 1);
    for (int i = 0; i < cnt; i++) begin
      if ($urandom_range(9) == 0) send_item(2'($urandom_range(3)), $urandom, 1'b1, dummy);
      pick = $urandom_range(9);
      w    = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
      send_item(KIND_ROW, w, 1'b1, dummy);
    end

    // Start from the true parities; the bits above the size carry junk.
    junk_mask = ~width_mask(n);
    rx   = row_parity_acc | ($urandom & junk_mask);
    col  = col_parity_acc | ($urandom & junk_mask);
    pick = $urandom_range(99);
    if (pick < 35) begin
      // clean matrix
    end else if (pick < 70) begin
      // single bit error: one row and one column disagree
      ri      = $urandom_range(n - 1);
      ci      = $urandom_range(n - 1);
      rx[ri]  = ~rx[ri];
      col[ci] = ~col[ci];
    end else if (pick < 80) begin
      ri     = $urandom_range(n - 1);
      rx[ri] = ~rx[ri];
    end else if (pick < 90) begin
      ci      = $urandom_range(n - 1);
      col[ci] = ~col[ci];
    end else begin
      rx  = $urandom;
      col = $urandom;
    end
    // Now and then the row-parity word is left out altogether.
    if ($urandom_range(19) != 0) send_item(KIND_RXROW, rx, 1'b1, dummy);
    send_item(KIND_CHECK, col, 1'b1, dummy);
  endtask

  // ---------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------
  // tready changes on the falling edge. A requested hold keeps it low for a
  // long stretch so that the unit backs up into its input.
  always @(negedge clk_i) begin
    if (hold_pending) begin
      hold_left    = HOLD_CYCLES;
      hold_pending = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : row_checker
    out_row_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (rows_due.size() == 0) begin
        $error("row word with no expectation waiting: 0x%0h", m_axis_tdata_o);
        mismatches++;
      end else begin
        want = rows_due.pop_front();
        check_field("row_bits",    want.bits,  m_axis_tdata_o[31:0]);
        check_field("row_index",   want.index, m_axis_tdata_o[36:32]);
        check_field("error_found", want.found, m_axis_tdata_o[37]);
        check_field("error_row",   want.erow,  m_axis_tdata_o[42:38]);
        check_field("error_col",   want.ecol,  m_axis_tdata_o[47:43]);
        check_field("last",        want.last,  m_axis_tlast_o);
      end
    end
  end

  // Watchdog: the run is stuck if no word moves on any channel for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_two_d_parity_error_correct_unit: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    script_step_t step;
    out_row_t     row;
    int           n;
    int           mode;
    int           reps;
    bit           pressure_done;
    logic [5:0]   size_pick;

    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    m_axis_tready_i = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    rst_ni          = 1'b0;
    mismatches      = 0;
    items_sent      = 0;
    quiet_cycles    = 0;
    hold_left       = 0;
    hold_pending    = 1'b0;
    pressure_done   = 1'b0;
    send_idle_pct   = 18;
    recv_idle_pct   = 61;
    row_parity_acc  = '0;
    col_parity_acc  = '0;
    rx_row_parity   = '0;
    rows_held       = 0;
    size_reg        = 6'd32;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Scripted opening.
    for (int s = 0; s < SCRIPT_LEN; s++) begin
      step = SCRIPT[s];
      if (step.op == DO_SIZE) begin
        write_size(step.word[5:0]);
      end else if (!step.typed) begin
        send_item(step.kind, step.word, 1'b1, n);
      end else begin
        send_item(step.kind, step.word, 1'b0, n);
        for (int i = 0; i < n; i++) begin
          row.bits  = (i == 0) ? step.bits0 : '0;
          row.index = 5'(i);
          row.found = step.found;
          row.erow  = step.erow;
          row.ecol  = step.ecol;
          row.last  = (i == n - 1);
          rows_due.push_back(row);
        end
      end
    end

    // Random matrices in phases: each round of matrices writes a new size. The idle
    // pattern moves from a slow receiver to a slow sender to no idling.
    while (items_sent < RANDOM_ITEMS) begin
      mode = items_sent * 3 / RANDOM_ITEMS;
      case (mode)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 61;
        end
        1: begin
          send_idle_pct = 61;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      size_pick = (mode >= 2 && !pressure_done) ? 6'd32 : random_size();
      write_size(size_pick);
      reps = $urandom_range(3, 1);
      if (mode >= 2 && !pressure_done) begin
        // Full-size matrices while the receiver stands still: the unit has
        // to hold its input off until the rows can drain.
        @(posedge clk_i);
        hold_pending  = 1'b1;
        pressure_done = 1'b1;
        reps          = 3;
      end
      repeat (reps) send_matrix();
    end

    drain_unit();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_two_d_parity_error_correct_unit: PASS");
    end else begin
      $display("tb_two_d_parity_error_correct_unit: FAIL");
    end
    $finish;
  end

endmodule
